@@ rtl/core/mish_pkg.sv @@
// shared constants, types and table functions for the mish activation unit
package mish_pkg;

  localparam int FRAC_BITS_DEF = 12;
  localparam int SAMPLE_W      = 16;
  // working precision of the datapath, fraction bits
  localparam int WF            = 52;
  // values in [0,1] with a whole-one bit
  localparam int TW            = WF + 1;
  // divider remainder, holds up to five
  localparam int RW            = WF + 3;
  localparam int ML            = (TW + 1) / 2;
  localparam int MH            = TW - ML;
  localparam int SERIES_TERMS  = 24;
  localparam int EXP_CUTOFF    = 48;

  typedef struct packed {
    logic                neg;
    logic [SAMPLE_W-1:0] mag;
    logic                last;
  } side_t;

  // partial products of a split TW x TW multiply
  typedef struct packed {
    logic [2*ML-1:0]  ll;
    logic [ML+MH-1:0] lh;
    logic [ML+MH-1:0] hl;
    logic [2*MH-1:0]  hh;
  } part_t;

  function automatic part_t mul_parts(input logic [TW-1:0] a, input logic [TW-1:0] b);
    part_t p;
    p.ll = a[ML-1:0]  * b[ML-1:0];
    p.lh = a[ML-1:0]  * b[TW-1:ML];
    p.hl = a[TW-1:ML] * b[ML-1:0];
    p.hh = a[TW-1:ML] * b[TW-1:ML];
    return p;
  endfunction

  // sum the partials and drop WF fraction bits
  function automatic logic [TW-1:0] mul_sum(input part_t p);
    logic [2*TW-1:0] full;
    full = (2*TW)'(p.ll)
         + ((2*TW)'(p.lh) << ML)
         + ((2*TW)'(p.hl) << ML)
         + ((2*TW)'(p.hh) << (2*ML));
    return full[WF+TW-1:WF];
  endfunction

  // exp(-y), y in [0,1], both in q2.62, alternating series
  function automatic logic [63:0] exp_neg_q62(input logic [63:0] y);
    logic [63:0]  sum;
    logic [63:0]  term;
    logic [127:0] prod;
    sum  = 64'd1 << 62;
    term = 64'd1 << 62;
    for (int k = 1; k <= SERIES_TERMS; k++) begin
      prod = {64'd0, term} * {64'd0, y};
      term = prod[125:62] / 64'(k);
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // round q2.62 to the datapath format
  function automatic logic [TW-1:0] q62_to_tab(input logic [63:0] x);
    logic [63:0] r;
    r = (x + (64'd1 << 9)) >> 10;
    return r[TW-1:0];
  endfunction

  // exp(-idx / 2^bits)
  function automatic logic [TW-1:0] tab_exp_frac(input int idx, input int bits);
    return q62_to_tab(exp_neg_q62(64'(idx) << (62 - bits)));
  endfunction

  // exp(-n), zero from the cutoff on
  function automatic logic [TW-1:0] tab_exp_int(input int n);
    logic [63:0]  e1;
    logic [63:0]  v;
    logic [127:0] prod;
    e1 = exp_neg_q62(64'd1 << 62);
    v  = 64'd1 << 62;
    for (int i = 0; i < EXP_CUTOFF; i++) begin
      if (i < n) begin
        prod = {64'd0, v} * {64'd0, e1};
        v    = prod[125:62];
      end
    end
    if (n >= EXP_CUTOFF) begin
      return '0;
    end
    return q62_to_tab(v);
  endfunction

endpackage

@@ rtl/core/mish_activation_unit.sv @@
// mish activation unit: streaming y = x * tanh(softplus(x)) on signed fixed-point samples
//
// usage
//  - input channel in_valid/in_ready carries one item: in_sample (signed, FRAC_BITS
//    fraction bits) and in_last_in (end-of-tensor marker)
//  - result channel out_valid/out_ready carries out_activation, the mish value rounded
//    to nearest (half away from zero) in the same format, and out_last_out, a copy of
//    the marker
//  - one item in, one result out per cycle unless the receiver stalls, in input order
//  - an item crosses every pipeline stage and then the output register; most stages form
//    the 52-stage restoring divider for tanh(softplus(x)), one quotient bit a stage
//  - exp(-|x|) is split into integer and two fraction chunks, each from a constant
//    table, then joined by two pipelined multiplies; every TW x TW multiply is four
//    partial products in one stage and their sum in the next
//  - when the receiver stalls, the output register holds, one more item parks in a
//    skid register, and in_ready drops the cycle after; the pipeline freezes as a
//    whole and nothing is lost or repeated
//  - reset (rst_n low, synchronous) empties the pipeline, the output and the skid
//    register; the tables are constants and need no fill time
module mish_activation_unit #(
  parameter int FRAC_BITS = mish_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_sample,
  input  logic        in_last_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_activation,
  output logic        out_last_out
);

  localparam int SW   = mish_pkg::SAMPLE_W;
  localparam int WF   = mish_pkg::WF;
  localparam int TW   = mish_pkg::TW;
  localparam int RW   = mish_pkg::RW;
  localparam int ML   = mish_pkg::ML;
  localparam int MH   = mish_pkg::MH;
  // index widths of the three exp tables
  localparam int NW   = SW - FRAC_BITS;
  localparam int FH   = (FRAC_BITS + 1) / 2;
  localparam int FL   = FRAC_BITS - FH;
  // stage map
  localparam int DIV0   = 8;
  localparam int ST_T   = DIV0 + WF + 1;
  localparam int ST_PM  = ST_T + 1;
  localparam int ST_RES = ST_PM + 1;
  localparam int NST    = ST_RES + 1;
  localparam int SUMW   = SW + TW + 1;

  localparam logic [RW-1:0] ONE_R   = RW'(1) << WF;
  localparam logic [TW-1:0] ONE_T   = TW'(1) << WF;
  localparam logic [SW:0]   MAX_NEG = (SW + 1)'(1) << (SW - 1);
  localparam logic [SW:0]   MAX_POS = MAX_NEG - 1'b1;

  // pipeline control: the whole pipe moves unless the skid register is occupied
  logic en;
  logic skid_vld_r;
  assign en       = !skid_vld_r;
  assign in_ready = en;

  logic              vld_r  [NST];
  mish_pkg::side_t   side_r [NST];
  mish_pkg::side_t   side_nxt;

  // sign and magnitude of the incoming sample
  always_comb begin
    side_nxt.neg  = in_sample[SW-1];
    side_nxt.mag  = in_sample[SW-1] ? (~in_sample + 1'b1) : in_sample;
    side_nxt.last = in_last_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // side info travels alongside the data of each stage
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      for (int k = 1; k < NST; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // exp tables: integer part, upper and lower fraction chunks
  logic [TW-1:0] tab_int [2**NW];
  logic [TW-1:0] tab_hi  [2**FH];
  logic [TW-1:0] tab_lo  [2**FL];

  for (genvar gi = 0; gi < 2**NW; gi++) begin : g_tab_int
    localparam logic [TW-1:0] VAL = mish_pkg::tab_exp_int(gi);
    assign tab_int[gi] = VAL;
  end
  for (genvar gh = 0; gh < 2**FH; gh++) begin : g_tab_hi
    localparam logic [TW-1:0] VAL = mish_pkg::tab_exp_frac(gh, FH);
    assign tab_hi[gh] = VAL;
  end
  for (genvar gl = 0; gl < 2**FL; gl++) begin : g_tab_lo
    localparam logic [TW-1:0] VAL = mish_pkg::tab_exp_frac(gl, FRAC_BITS);
    assign tab_lo[gl] = VAL;
  end

  logic [NW-1:0] n_idx;
  logic [FH-1:0] fh_idx;
  logic [FL-1:0] fl_idx;
  assign n_idx  = side_r[0].mag[SW-1:FRAC_BITS];
  assign fh_idx = side_r[0].mag[FRAC_BITS-1:FL];
  assign fl_idx = side_r[0].mag[FL-1:0];

  // stages 1 to 7: v = exp(-|x|) and w = v^2
  logic [TW-1:0]     ti_r, ta_r, tb_r, tb2_r, tb3_r;
  mish_pkg::part_t   m1_r, m2_r, m3_r;
  logic [TW-1:0]     p1_r, v5_r, v6_r, v7_r, w7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ti_r  <= tab_int[n_idx];
      ta_r  <= tab_hi[fh_idx];
      tb_r  <= tab_lo[fl_idx];
      m1_r  <= mish_pkg::mul_parts(ti_r, ta_r);
      tb2_r <= tb_r;
      p1_r  <= mish_pkg::mul_sum(m1_r);
      tb3_r <= tb2_r;
      m2_r  <= mish_pkg::mul_parts(p1_r, tb3_r);
      v5_r  <= mish_pkg::mul_sum(m2_r);
      m3_r  <= mish_pkg::mul_parts(v5_r, v5_r);
      v6_r  <= v5_r;
      w7_r  <= mish_pkg::mul_sum(m3_r);
      v7_r  <= v6_r;
    end
  end

  // stage 8: numerator and denominator of the rational form
  //   x >= 0 : t = 1 - 2w / (1 + 2v + 2w)
  //   x <  0 : t = (w + 2v) / (w + 2v + 2)
  logic [RW-1:0] num_nxt, den_nxt;
  logic [RW-1:0] rem_r [WF];
  logic [RW-1:0] den_r [WF];
  logic [WF-1:0] q_r   [WF];

  always_comb begin
    if (side_r[DIV0-1].neg) begin
      num_nxt = RW'(w7_r) + (RW'(v7_r) << 1);
      den_nxt = num_nxt + (ONE_R << 1);
    end else begin
      num_nxt = RW'(w7_r) << 1;
      den_nxt = ONE_R + (RW'(v7_r) << 1) + (RW'(w7_r) << 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num_nxt;
      den_r[0] <= den_nxt;
    end
  end

  // divider: one restoring step per stage, one quotient bit each
  for (genvar j = 1; j <= WF; j++) begin : g_div
    logic [RW:0]   r2;
    logic          ge;
    logic [RW:0]   diff;
    logic [WF-1:0] q_in;

    assign r2   = {rem_r[j-1], 1'b0};
    assign ge   = r2 >= {1'b0, den_r[j-1]};
    assign diff = r2 - {1'b0, den_r[j-1]};

    if (j == 1) begin : g_first
      assign q_in = '0;
    end else begin : g_next
      assign q_in = q_r[j-2];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[j-1] <= {q_in[WF-2:0], ge};
      end
    end

    if (j < WF) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= ge ? diff[RW-1:0] : r2[RW-1:0];
          den_r[j] <= den_r[j-1];
        end
      end
    end
  end

  // t = tanh(softplus(x)), then |x| * t as two partial products, then round
  logic [TW-1:0]    t_r;
  logic [SW+ML-1:0] pm_lo_r;
  logic [SW+MH-1:0] pm_hi_r;
  logic [SW-1:0]    res_r;
  logic [SUMW-1:0]  prod_sum;
  logic [SW:0]      res_mag;
  logic [SW:0]      res_sat;
  logic [SW-1:0]    res_nxt;

  always_comb begin
    prod_sum = SUMW'(pm_lo_r) + (SUMW'(pm_hi_r) << ML) + (SUMW'(1) << (WF - 1));
    res_mag  = prod_sum[WF+SW:WF];
    if (side_r[ST_PM].neg) begin
      res_sat = (res_mag > MAX_NEG) ? MAX_NEG : res_mag;
      res_nxt = ~res_sat[SW-1:0] + 1'b1;
    end else begin
      res_sat = (res_mag > MAX_POS) ? MAX_POS : res_mag;
      res_nxt = res_sat[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r     <= side_r[ST_T-1].neg ? {1'b0, q_r[WF-1]} : (ONE_T - {1'b0, q_r[WF-1]});
      pm_lo_r <= side_r[ST_T].mag * t_r[ML-1:0];
      pm_hi_r <= side_r[ST_T].mag * t_r[TW-1:ML];
      res_r   <= res_nxt;
    end
  end

  // output register with a skid register behind it
  logic          out_valid_r, out_valid_nxt;
  logic [SW-1:0] out_act_r, out_act_nxt;
  logic          out_last_r, out_last_nxt;
  logic          skid_vld_nxt;
  logic [SW-1:0] skid_act_r, skid_act_nxt;
  logic          skid_last_r, skid_last_nxt;
  logic          pipe_vld;
  logic          out_free;

  assign pipe_vld = vld_r[NST-1];
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_act_nxt   = out_act_r;
    out_last_nxt  = out_last_r;
    skid_vld_nxt  = skid_vld_r;
    skid_act_nxt  = skid_act_r;
    skid_last_nxt = skid_last_r;
    if (out_free) begin
      if (skid_vld_r) begin
        out_valid_nxt = 1'b1;
        out_act_nxt   = skid_act_r;
        out_last_nxt  = skid_last_r;
        skid_vld_nxt  = 1'b0;
      end else if (pipe_vld) begin
        out_valid_nxt = 1'b1;
        out_act_nxt   = res_r;
        out_last_nxt  = side_r[NST-1].last;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (pipe_vld && en) begin
      // receiver stalled: park the item leaving the pipe
      skid_vld_nxt  = 1'b1;
      skid_act_nxt  = res_r;
      skid_last_nxt = side_r[NST-1].last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_vld_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_vld_r  <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_act_r   <= out_act_nxt;
    out_last_r  <= out_last_nxt;
    skid_act_r  <= skid_act_nxt;
    skid_last_r <= skid_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_activation = out_act_r;
  assign out_last_out   = out_last_r;

  // the skid register only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_valid_r)
    else $error("skid register holds an item with the output register empty");

  // zero in, zero out
  a_zero_in_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_RES] && (side_r[ST_RES].mag == '0) |-> (res_r == '0))
    else $error("non-zero result for a zero sample");

  // tanh(softplus(x)) <= 1, so a positive sample never grows
  a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_RES] && !side_r[ST_RES].neg |-> !res_r[SW-1] && (res_r <= side_r[ST_RES].mag))
    else $error("result of a positive sample out of range");

  // a negative sample gives zero or a negative result
  a_neg_sign: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_RES] && side_r[ST_RES].neg |-> (res_r == '0) || res_r[SW-1])
    else $error("positive result for a negative sample");

endmodule

@@ verif/tb_mish_activation_unit.sv @@
// self-checking testbench for the mish activation unit: directed and random q4.12 samples
module tb_mish_activation_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // fixed-point layout shared with the block
  localparam int SAMPLE_W     = mish_pkg::SAMPLE_W;
  localparam int SERIES_TERMS = mish_pkg::SERIES_TERMS;
  localparam int EXP_CUTOFF   = mish_pkg::EXP_CUTOFF;
  localparam int FRAC = mish_pkg::FRAC_BITS_DEF;
  localparam logic [63:0] Q62_ONE = 64'd1 << 62;
  localparam logic [63:0] Q60_ONE = 64'd1 << 60;

  // handshake pressure
  localparam int IDLE_PCT  = 27;
  localparam int HOLD_AT   = 150;  // items taken before the long receiver hold-off
  localparam int HOLD_LEN  = 300;  // cycles of that hold-off
  localparam int TAIL_WAIT = 80;   // idle cycles after the final drain
  localparam int MAX_SHOWN = 20;   // mismatch lines printed before going quiet

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } sample_item_t;

  typedef struct {
    logic [SAMPLE_W-1:0] act;
    logic                last;
  } mish_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [15:0] in_sample = '0;
  logic in_last_in = 1'b0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  logic [15:0] out_activation;
  logic out_last_out;

  mish_activation_unit #(
    .FRAC_BITS(FRAC)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .in_last_in    (in_last_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_activation(out_activation),
    .out_last_out  (out_last_out)
  );

  always #1 clk = ~clk;

  // samples waiting for the driver, results waiting for the monitor
  sample_item_t pending_samples[$];
  mish_result_t awaited_results[$];

  logic in_taken = 1'b0;  // the item on the input was taken at the last rising edge
  logic calm = 1'b0;      // no idling on either side
  sample_item_t next_item;

  int n_queued = 0;
  int n_taken = 0;
  int n_checked = 0;
  int n_neg = 0;
  int n_last = 0;
  int n_stalled = 0;
  int n_errors = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;

  // ---------------------------------------------------------------------------
  // mish predictor, q4.12 in and out
  // ---------------------------------------------------------------------------

  // truncating fixed-point product, (a*b) >> sh kept to 64 bits
  function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b,
                                         input int sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> sh;
    return p[63:0];
  endfunction

  // exp(-y), y in [0,1], q2.62, alternating taylor series with truncated terms
  function automatic logic [63:0] decay_q62(input logic [63:0] y);
    logic [63:0] acc;
    logic [63:0] term;
    acc  = Q62_ONE;
    term = Q62_ONE;
    for (int k = 1; k <= SERIES_TERMS; k++) begin
      term = fx_mul(term, y, 62) / 64'(k);
      if (k % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    return acc;
  endfunction

  // floor(num * 2^60 / den), restoring division, num < den
  function automatic logic [63:0] ratio_q60(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = num;
    quo = '0;
    for (int i = 0; i < 60; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem    = rem - den;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [SAMPLE_W-1:0] mish_q412(input logic [SAMPLE_W-1:0] x);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] whole;
    logic [63:0] frac;
    logic [63:0] v;
    logic [63:0] e_inv;
    logic [63:0] v60;
    logic [63:0] vsq;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] t;
    logic [63:0] res;
    neg   = x[SAMPLE_W-1];
    mag   = neg ? (64'h10000 - 64'(x)) : 64'(x);
    whole = mag >> FRAC;
    frac  = mag & ((64'd1 << FRAC) - 64'd1);
    // v = exp(-|x|), forced to zero far out where tanh(softplus) is exact
    if (whole >= 64'(EXP_CUTOFF)) begin
      v = '0;
    end else begin
      e_inv = decay_q62(Q62_ONE);
      v     = decay_q62(frac << (62 - FRAC));
      for (int i = 0; i < int'(whole); i++) begin
        v = fx_mul(v, e_inv, 62);
      end
    end
    v60 = v >> 2;
    vsq = fx_mul(v60, v60, 60);
    // tanh(softplus(x)) as a rational in v
    if (!neg) begin
      num = 64'd2 * vsq;
      den = Q60_ONE + 64'd2 * v60 + 64'd2 * vsq;
      t   = Q60_ONE - ratio_q60(num, den);
    end else begin
      num = vsq + 64'd2 * v60;
      den = num + 64'd2 * Q60_ONE;
      t   = ratio_q60(num, den);
    end
    t   = t >> 12;
    // round magnitude half away from zero, then clamp and restore the sign
    res = (mag * t + (64'd1 << 47)) >> 48;
    if (neg) begin
      if (res > 64'h8000) begin
        res = 64'h8000;
      end
      res = (64'h10000 - res) & 64'hFFFF;
    end else if (res > 64'h7FFF) begin
      res = 64'h7FFF;
    end
    return res[SAMPLE_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers items from the pending queue, changes inputs on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (in_valid && !in_taken) begin
      // item still on offer, hold it unchanged
    end else if (pending_samples.size() != 0 &&
                 (calm || $urandom_range(99) >= IDLE_PCT)) begin
      next_item = pending_samples.pop_front();
      in_valid   <= 1'b1;
      in_sample  <= next_item.sample;
      in_last_in <= next_item.last;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver: random ready, plus one long hold-off so the pipeline and skid fill up
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && n_taken >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks results, then records the expectation of each item taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    mish_result_t exp_r;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      n_checked++;
      if (awaited_results.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_SHOWN) begin
          $display("%0t: unexpected result activation=%h last=%b",
                   $time, out_activation, out_last_out);
        end
      end else begin
        exp_r = awaited_results.pop_front();
        if (out_activation !== exp_r.act) begin
          n_errors++;
          if (n_errors <= MAX_SHOWN) begin
            $display("%0t: activation mismatch expected=%h actual=%h",
                     $time, exp_r.act, out_activation);
          end
        end
        if (out_last_out !== exp_r.last) begin
          n_errors++;
          if (n_errors <= MAX_SHOWN) begin
            $display("%0t: last marker mismatch expected=%b actual=%b",
                     $time, exp_r.last, out_last_out);
          end
        end
      end
    end
    if (rst_n && in_valid) begin
      if (in_ready) begin
        awaited_results.push_back('{mish_q412(in_sample), in_last_in});
        n_taken++;
        if (in_sample[SAMPLE_W-1]) begin
          n_neg++;
        end
        if (in_last_in) begin
          n_last++;
        end
      end else begin
        n_stalled++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_item(input logic [15:0] s, input logic l);
    pending_samples.push_back('{s, l});
    n_queued++;
  endtask

  // sender pause: nothing new until every expected result has come back
  task automatic drain();
    while (n_taken != n_queued || awaited_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // half full-range samples, the rest clustered near zero and around the curve's dip
  task automatic queue_random(input int count);
    logic [15:0] s;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        s = 16'($urandom_range(16'hFFFF));
      end else if (pick < 75) begin
        s = 16'($urandom_range(16383) - 8192);
      end else if (pick < 90) begin
        s = 16'($urandom_range(127) - 64);
      end else begin
        s = 16'($urandom_range(2047) - 5900);
      end
      queue_item(s, $urandom_range(15) == 0);
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: zero, smallest steps, both range ends, whole numbers, the dip
    queue_item(16'h0000, 1'b0);
    queue_item(16'h0001, 1'b0);
    queue_item(16'hFFFF, 1'b0);
    queue_item(16'h7FFF, 1'b0);
    queue_item(16'h8000, 1'b1);
    queue_item(16'h8001, 1'b0);
    queue_item(16'h7FFE, 1'b0);
    queue_item(16'h1000, 1'b0);
    queue_item(16'hF000, 1'b0);
    queue_item(16'h0FFF, 1'b0);
    queue_item(16'hF001, 1'b0);
    queue_item(16'h0800, 1'b0);
    queue_item(16'hF800, 1'b1);
    queue_item(16'hECF5, 1'b0);  // near the minimum, about -1.19
    queue_item(16'h7000, 1'b0);
    queue_item(16'h9000, 1'b0);
    queue_item(16'h0003, 1'b0);
    queue_item(16'hFFFD, 1'b0);
    queue_item(16'h5555, 1'b0);
    queue_item(16'hAAAA, 1'b1);
    drain();

    // random with idling on both sides, including the long receiver hold-off
    queue_random(350);
    drain();

    // a stretch at full rate, no idling at all
    calm = 1'b1;
    queue_random(200);
    drain();
    calm = 1'b0;

    queue_random(300);
    drain();

    // any stray result in the tail is caught by the monitor
    repeat (TAIL_WAIT) @(negedge clk);

    $display("checked %0d results from %0d samples (%0d negative, %0d end markers)",
             n_checked, n_taken, n_neg, n_last);
    $display("input held back for %0d cycles, %0d errors", n_stalled, n_errors);
    if (n_errors == 0 && awaited_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200us;
    $display("watchdog expired at %0t", $time);
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/mish_pkg.sv
rtl/core/mish_activation_unit.sv
verif/tb_mish_activation_unit.sv
